### rtl/nhct_pkg.sv
// Package of shared types and constants for the neighborhood hash count table.
package nhct_pkg;

    localparam int NUM_BUCKETS_DEF = 256;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int KEY_W = 32;
    localparam int CNT_W = 32;
    localparam int POS_W = 10;
    localparam int NB_W = 9;
    localparam int WORD_W = SLOTS_PER_BUCKET * (KEY_W + CNT_W);

    localparam logic [KEY_W-1:0] HASH_MULT = 32'd1300000077;
    localparam logic [NB_W-1:0] NB_RESET = 9'd4;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic {
        REQ_PROBE = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        ST_FOUND       = 3'd0,
        ST_INSERTED    = 3'd1,
        ST_FREE_BEYOND = 3'd2,
        ST_FULL        = 3'd3,
        ST_CLEARED     = 3'd4
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   pos;
        logic [CNT_W-1:0]   cnt;
    } t_result;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_RD,
        S_CHK,
        S_CLR,
        S_PUT
    } t_state;

endpackage

### rtl/nhct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module nhct_ram #(
    parameter int WIDTH = nhct_pkg::WORD_W,
    parameter int DEPTH = nhct_pkg::NUM_BUCKETS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/neighborhood_hash_count_table.sv
// Top level of the neighborhood hash count table: a group-by count store of buckets of
// four key/count slots, one bucket per word of a single RAM. A probe reads buckets from
// its home bucket onward: the RAM delivers one bucket per cycle and the walk ends at the
// first free slot or slot matching within the neighborhood, or at the last bucket. When
// NUM_BUCKETS is not a power of two, the home bucket comes from a reciprocal
// multiplication with one correction step in an extra modulo state. A probe with key 0
// skips the walk and reports full. A clear request writes every bucket once. A finished
// result waits for the receiver while the previous one is still held, and no new
// transaction is accepted until it moves on.
// After reset a clearing pass over every bucket runs before the first transaction is
// accepted; configuration writes are taken at any time.
module neighborhood_hash_count_table #(
    parameter int NUM_BUCKETS = nhct_pkg::NUM_BUCKETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // key
    input  logic        i_s_axis_tuser,   // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // slot_position, count, zero fill
    output logic [2:0]  o_m_axis_tuser    // status
);

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int SLOT_NUM = NUM_BUCKETS * nhct_pkg::SLOTS_PER_BUCKET;
    localparam int LW = BW + 2;
    localparam bit SLOT_POW2 = ((SLOT_NUM & (SLOT_NUM - 1)) == 0);
    localparam logic [LW:0] SLOT_NUM_W = (LW + 1)'(SLOT_NUM);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);
    localparam int KW = nhct_pkg::KEY_W;
    localparam int CW = nhct_pkg::CNT_W;
    localparam int NBW = nhct_pkg::NB_W;
    localparam int CNT_BASE = nhct_pkg::SLOTS_PER_BUCKET * KW;
    localparam logic [KW-1:0] RECIP = KW'(64'h1_0000_0000 / SLOT_NUM);

    nhct_pkg::t_state  r_state, n_state;
    logic [KW-1:0]     r_key, n_key;
    logic [KW-1:0]     r_hash, n_hash;
    logic [LW:0]       r_quo, n_quo;
    logic [BW-1:0]     r_bucket, n_bucket;
    logic [NBW-1:0]    r_off, n_off;
    logic [NBW-1:0]    r_nb, n_nb;
    nhct_pkg::t_result r_res, n_res;
    logic              r_oval, n_oval;
    nhct_pkg::t_result r_out, n_out;

    logic                       ram_we;
    logic [BW-1:0]              ram_waddr;
    logic [BW-1:0]              ram_raddr;
    logic [nhct_pkg::WORD_W-1:0] ram_wdata;
    logic [nhct_pkg::WORD_W-1:0] ram_rdata;

    logic            in_fire;
    logic            put_fire;
    logic [2*KW-1:0] quo_prod;
    logic [LW:0]     mod_t;
    logic [LW:0]     mod_r;
    logic            in_reach;
    logic            hit;
    logic            is_match;
    logic [1:0]      sel;
    logic [KW-1:0]   sel_key;
    logic [CW-1:0]   sel_cnt;
    logic [CW-1:0]   inc_cnt;
    logic [31:0]     pos_full;
    logic            last_bucket;

    nhct_ram #(
        .WIDTH(nhct_pkg::WORD_W),
        .DEPTH(NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_axis_tready = (r_state == nhct_pkg::S_IDLE);
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign put_fire = (r_state == nhct_pkg::S_PUT) && (!r_oval || i_m_axis_tready);

    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata = {6'd0, r_out.cnt, r_out.pos};
    assign o_m_axis_tuser = r_out.status;

    // The estimated quotient is at most one below the true one, so one subtraction fixes it.
    assign quo_prod = {{KW{1'b0}}, r_hash} * {{KW{1'b0}}, RECIP};
    assign mod_t = r_hash[LW:0] - r_quo * SLOT_NUM_W;
    assign mod_r = (mod_t >= SLOT_NUM_W) ? (mod_t - SLOT_NUM_W) : mod_t;

    assign in_reach = (r_off < r_nb);
    assign last_bucket = (r_bucket == LAST_BUCKET);

    always_comb begin
        hit = 1'b0;
        sel = 2'd0;
        for (int s = nhct_pkg::SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
            if ((ram_rdata[s*KW +: KW] == '0) ||
                (in_reach && (ram_rdata[s*KW +: KW] == r_key))) begin
                hit = 1'b1;
                sel = 2'(s);
            end
        end
    end

    assign sel_key = ram_rdata[32'(sel)*KW +: KW];
    assign sel_cnt = ram_rdata[CNT_BASE + 32'(sel)*CW +: CW];
    assign is_match = (sel_key == r_key);
    assign inc_cnt = (sel_cnt == nhct_pkg::CNT_MAX) ? sel_cnt : (sel_cnt + 1'b1);
    assign pos_full = {{(32 - LW){1'b0}}, r_bucket, sel};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nhct_pkg::S_INIT: begin
                if (last_bucket) begin
                    n_state = nhct_pkg::S_IDLE;
                end
            end
            nhct_pkg::S_IDLE: begin
                if (in_fire) begin
                    priority if (i_s_axis_tuser == nhct_pkg::REQ_CLEAR) begin
                        n_state = nhct_pkg::S_CLR;
                    end else if (i_s_axis_tdata == '0) begin
                        n_state = nhct_pkg::S_PUT;
                    end else begin
                        n_state = nhct_pkg::S_HASH;
                    end
                end
            end
            nhct_pkg::S_HASH: begin
                n_state = SLOT_POW2 ? nhct_pkg::S_RD : nhct_pkg::S_MOD;
            end
            nhct_pkg::S_MOD: begin
                n_state = nhct_pkg::S_RD;
            end
            nhct_pkg::S_RD: begin
                n_state = nhct_pkg::S_CHK;
            end
            nhct_pkg::S_CHK: begin
                if (hit || last_bucket) begin
                    n_state = nhct_pkg::S_PUT;
                end
            end
            nhct_pkg::S_CLR: begin
                if (last_bucket) begin
                    n_state = nhct_pkg::S_PUT;
                end
            end
            nhct_pkg::S_PUT: begin
                if (put_fire) begin
                    n_state = nhct_pkg::S_IDLE;
                end
            end
            default: n_state = nhct_pkg::S_INIT;
        endcase
    end

    always_comb begin
        n_key = r_key;
        n_hash = r_hash;
        n_quo = r_quo;
        n_bucket = r_bucket;
        n_off = r_off;
        n_res = r_res;
        n_out = r_out;
        n_oval = r_oval && !i_m_axis_tready;
        ram_we = 1'b0;
        ram_waddr = r_bucket;
        ram_wdata = ram_rdata;
        ram_raddr = r_bucket;
        unique case (r_state)
            nhct_pkg::S_INIT, nhct_pkg::S_CLR: begin
                ram_we = 1'b1;
                ram_wdata = '0;
                n_bucket = r_bucket + 1'b1;
                n_res = '{status: nhct_pkg::ST_CLEARED, pos: '0, cnt: '0};
            end
            nhct_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_key = i_s_axis_tdata;
                    n_hash = i_s_axis_tdata * nhct_pkg::HASH_MULT;
                    n_bucket = '0;
                    n_res = '{status: nhct_pkg::ST_FULL, pos: '0, cnt: '0};
                end
            end
            nhct_pkg::S_HASH: begin
                n_bucket = r_hash[LW-1:2];
                n_quo = quo_prod[KW+LW:KW];
            end
            nhct_pkg::S_MOD: begin
                n_bucket = mod_r[LW-1:2];
            end
            nhct_pkg::S_RD: begin
                n_off = '0;
            end
            nhct_pkg::S_CHK: begin
                ram_raddr = r_bucket + 1'b1;
                priority if (hit && in_reach && is_match) begin
                    ram_we = 1'b1;
                    ram_wdata[CNT_BASE + 32'(sel)*CW +: CW] = inc_cnt;
                    n_res = '{status: nhct_pkg::ST_FOUND, pos: pos_full[9:0], cnt: inc_cnt};
                end else if (hit && in_reach) begin
                    ram_we = 1'b1;
                    ram_wdata[32'(sel)*KW +: KW] = r_key;
                    ram_wdata[CNT_BASE + 32'(sel)*CW +: CW] = CW'(1);
                    n_res = '{status: nhct_pkg::ST_INSERTED, pos: pos_full[9:0],
                              cnt: CW'(1)};
                end else if (hit) begin
                    n_res = '{status: nhct_pkg::ST_FREE_BEYOND, pos: pos_full[9:0],
                              cnt: '0};
                end else if (last_bucket) begin
                    n_res = '{status: nhct_pkg::ST_FULL, pos: '0, cnt: '0};
                end else begin
                    n_bucket = r_bucket + 1'b1;
                    n_off = (r_off == '1) ? r_off : (r_off + 1'b1);
                end
            end
            nhct_pkg::S_PUT: begin
                if (put_fire) begin
                    n_out = r_res;
                    n_oval = 1'b1;
                end
            end
            default: begin
                n_bucket = '0;
            end
        endcase
    end

    always_comb begin
        n_nb = r_nb;
        if (i_cfg_wen) begin
            n_nb = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nhct_pkg::S_INIT;
            r_bucket <= '0;
            r_oval <= 1'b0;
            r_nb <= nhct_pkg::NB_RESET;
            r_off <= '0;
        end else begin
            r_state <= n_state;
            r_bucket <= n_bucket;
            r_oval <= n_oval;
            r_nb <= n_nb;
            r_off <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_hash <= n_hash;
        r_quo <= n_quo;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule
